// File: hw/rtl/olide_pkg.sv
package olide_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [KIND_W-1:0] {
    K_FRONT     = 3'd0,
    K_BACK      = 3'd1,
    K_BEFORE    = 3'd2,
    K_AFTER     = 3'd3,
    K_DEL_KEY   = 3'd4,
    K_DEL_PRED  = 3'd5,
    K_DEL_SUCC  = 3'd6,
    K_DUMP      = 3'd7
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DUMP
  } fsm_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e op;
    idx_t     pos;
    idx_t     last_idx;
    value_t   new_value;
    value_t   key;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/olide_cell.sv
module olide_cell
  import olide_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  idx_t       idx_i,
  input  value_t     left_i,
  input  value_t     right_i,
  input  value_t     head_i,
  output value_t     value_o,
  output logic       match_o
);

  value_t value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      CELL_HOLD: value_d = value_q;
      CELL_INSERT: begin
        // open a gap at pos: cells above take their left neighbor
        if (idx_i == ctrl_i.pos) begin
          value_d = ctrl_i.new_value;
        end else if (idx_i > ctrl_i.pos) begin
          value_d = left_i;
        end
      end
      CELL_REMOVE: begin
        // close the gap at pos
        if (idx_i >= ctrl_i.pos) begin
          value_d = right_i;
        end
      end
      CELL_ROTATE: begin
        // rotate the occupied part of the chain by one toward the head
        if (idx_i == ctrl_i.last_idx) begin
          value_d = head_i;
        end else if (idx_i < ctrl_i.last_idx) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (value_q == ctrl_i.key);

endmodule

// File: hw/rtl/ordered_list_insert_delete_engine_top.sv
// Ordered list engine: a circular list of up to DEPTH signed 32-bit values,
// head at position 0, held in a chain of cells that shift toward or away
// from the head to insert or remove an entry.
//
// Input channel (s_axis): one transfer is one command. tuser carries the
// command kind, tdata the inserted value and the search key.
// Output channel (m_axis): every command returns one result with tlast set;
// a dump of a non-empty list returns one result per entry, tlast on the last.
//
// Sequence: a command is taken in the idle state and executed in the exec
// state; the block takes no new command until it is back in idle.
// The key compare runs in all cells in parallel, followed by a first-match
// priority pick; the insert or remove shift happens in the same cycle.
// A dump passes through take and setup, then emits one entry per step:
// each step rotates the chain by one cell, so the list ends back in place.
//
// Reset empties the list (count cleared); cell contents are not cleared.
// A stalled receiver holds the result register; execution waits until the
// result register is free, and no new command is taken meanwhile.
module ordered_list_insert_delete_engine_top
  import olide_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side: commands
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] new_value, [63:32] key
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  // master side: results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [33:2] out_value, [38:34] entry_count, [39] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  fsm_e   state_q, state_d;
  cnt_t   count_q, count_d;
  idx_t   dump_cnt_q, dump_cnt_d;
  kind_e  kind_q;
  value_t new_value_q, key_q;

  // result register
  logic    out_valid_q, out_valid_d;
  status_e out_status_q, out_status_d;
  value_t  out_value_q, out_value_d;
  cnt_t    out_count_q, out_count_d;
  logic    out_last_q, out_last_d;

  cell_ctrl_t       ctrl;
  value_t           cell_val [DEPTH];
  logic [DEPTH-1:0] cell_match;

  logic out_free;
  logic full, empty;
  logic hit;
  idx_t hit_idx;
  idx_t last_idx;
  idx_t del_pos;
  cnt_t count_m1;

  // ---------------------------------------------------------------------------
  // cell chain
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    value_t left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    olide_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .left_i  (left_v),
      .right_i (right_v),
      .head_i  (cell_val[0]),
      .value_o (cell_val[g]),
      .match_o (cell_match[g])
    );
  end

  // ---------------------------------------------------------------------------
  // first match among the occupied cells
  // ---------------------------------------------------------------------------
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i] && (CNT_W'(i) < count_q)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];

  // position removed by the delete kinds
  always_comb begin
    del_pos = hit_idx;
    if (kind_q == K_DEL_PRED) begin
      del_pos = (hit_idx == '0) ? last_idx : hit_idx - IDX_W'(1);
    end else if (kind_q == K_DEL_SUCC) begin
      del_pos = (hit_idx == last_idx) ? '0 : hit_idx + IDX_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    dump_cnt_d     = dump_cnt_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_status_d   = out_status_q;
    out_value_d    = out_value_q;
    out_count_d    = out_count_q;
    out_last_d     = out_last_q;
    ctrl.op        = CELL_HOLD;
    ctrl.pos       = '0;
    ctrl.last_idx  = last_idx;
    ctrl.new_value = new_value_q;
    ctrl.key       = key_q;
    s_axis_tready  = 1'b0;

    unique case (state_q)
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        if (out_free) begin
          // default: single final result, nothing removed
          state_d      = FSM_IDLE;
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          unique case (kind_q)
            K_FRONT, K_BACK: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                ctrl.op  = CELL_INSERT;
                ctrl.pos = (kind_q == K_FRONT) ? '0 : count_q[IDX_W-1:0];
                count_d  = count_q + CNT_W'(1);
              end
            end
            K_DUMP: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                // hand over to the dump loop, no result here
                out_valid_d = out_valid_q && !m_axis_tready;
                dump_cnt_d  = '0;
                state_d     = FSM_DUMP;
              end
            end
            K_BEFORE, K_AFTER: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else if (!hit) begin
                out_status_d = ST_NOT_FOUND;
              end else if (full) begin
                out_status_d = ST_FULL;
              end else begin
                ctrl.op  = CELL_INSERT;
                ctrl.pos = (kind_q == K_BEFORE) ? hit_idx : hit_idx + IDX_W'(1);
                count_d  = count_q + CNT_W'(1);
              end
            end
            K_DEL_KEY, K_DEL_PRED, K_DEL_SUCC: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else if (!hit) begin
                out_status_d = ST_NOT_FOUND;
              end else begin
                ctrl.op     = CELL_REMOVE;
                ctrl.pos    = del_pos;
                out_value_d = cell_val[del_pos];
                count_d     = count_m1;
              end
            end
            default: out_status_d = ST_OK;
          endcase
          out_count_d = count_d;
        end
      end

      FSM_DUMP: begin
        if (out_free) begin
          // emit the head, then rotate the next entry into it
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_value_d  = cell_val[0];
          out_count_d  = count_q;
          out_last_d   = (dump_cnt_q == last_idx);
          ctrl.op      = CELL_ROTATE;
          if (dump_cnt_q == last_idx) begin
            state_d = FSM_IDLE;
          end else begin
            dump_cnt_d = dump_cnt_q + IDX_W'(1);
          end
        end
      end

      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      dump_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_cnt_q  <= dump_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q      <= kind_e'(s_axis_tuser);
      new_value_q <= s_axis_tdata[VAL_W-1:0];
      key_q       <= s_axis_tdata[2*VAL_W-1:VAL_W];
    end
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_value_q, out_status_q};

endmodule
